/* sv/rtbp_pkg.sv */
`default_nettype none
package rtbp_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [8:0] RED_W_RST   = 9'd77;
    localparam logic [8:0] GREEN_W_RST = 9'd150;
    localparam logic [8:0] BLUE_W_RST  = 9'd29;
    localparam logic [7:0] THRESH_RST  = 8'd46;
    localparam logic [7:0] FULL_SCALE  = 8'hFF;

    typedef enum logic [2:0] {
        CFG_RED_W   = 3'd0,
        CFG_GREEN_W = 3'd1,
        CFG_BLUE_W  = 3'd2,
        CFG_THRESH  = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       dest_bit;
        logic       last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic [3:0] valid_pixels;
        logic       end_of_run;
    } t_out_item;

    // classified pixel handed from front to packer
    typedef struct packed {
        logic pix_bit;
        logic last;
    } t_cls;

    typedef struct packed {
        logic [8:0] red_w;
        logic [8:0] green_w;
        logic [8:0] blue_w;
        logic [7:0] thresh;
    } t_cfg;

endpackage
`default_nettype wire

/* sv/rtbp_front.sv */
`default_nettype none
module rtbp_front
    import rtbp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_push,
    input  wire logic     i_q_ready,
    output t_cls          o_cls
);

    logic en;

    // stage 1: weighted products
    logic        r_v1;
    logic [16:0] r_pr1, r_pg1, r_pb1;
    logic        r_plain1, r_clear1, r_dest1, r_last1;
    logic [7:0]  r_alpha1;

    // stage 2: luma, saturation, plain threshold
    logic        r_v2;
    logic [7:0]  r_gray2;
    logic        r_ge2;
    logic        r_plain2, r_clear2, r_dest2, r_last2;
    logic [7:0]  r_alpha2;

    // stage 3: blend sum
    logic        r_v3;
    logic [15:0] r_mix3;
    logic        r_ge3, r_plain3, r_clear3, r_dest3, r_last3;

    logic [18:0] n_sum;
    logic [7:0]  n_gray;
    logic [7:0]  n_inv;
    logic [15:0] n_dterm;
    logic [15:0] n_mix;
    logic [15:0] thr255;

    assign en      = !r_v3 || i_q_ready;
    assign o_ready = en;
    assign o_push  = r_v3 && i_q_ready;

    always_comb begin
        n_sum   = 19'(r_pr1) + 19'(r_pg1) + 19'(r_pb1);
        n_gray  = (n_sum[18:16] != 3'd0) ? FULL_SCALE : n_sum[15:8];
        n_inv   = FULL_SCALE - r_alpha2;
        // 255 * (255 - alpha) when the destination bit is set
        n_dterm = r_dest2 ? ({n_inv, 8'd0} - 16'(n_inv)) : 16'd0;
        n_mix   = 16'(r_gray2 * r_alpha2) + n_dterm;
        // floor(mix/255) >= t  <=>  mix >= 255*t
        thr255  = {i_cfg.thresh, 8'd0} - 16'(i_cfg.thresh);
    end

    always_comb begin
        o_cls.last = r_last3;
        if (r_plain3) begin
            o_cls.pix_bit = r_ge3;
        end else if (r_clear3) begin
            o_cls.pix_bit = r_dest3;
        end else begin
            o_cls.pix_bit = (r_mix3 >= thr255);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pr1    <= i_item.red * i_cfg.red_w;
            r_pg1    <= i_item.green * i_cfg.green_w;
            r_pb1    <= i_item.blue * i_cfg.blue_w;
            r_plain1 <= !i_item.func || (i_item.alpha == FULL_SCALE);
            r_clear1 <= (i_item.alpha == 8'd0);
            r_dest1  <= i_item.dest_bit;
            r_last1  <= i_item.last_pixel;
            r_alpha1 <= i_item.alpha;

            r_gray2  <= n_gray;
            r_ge2    <= (n_gray >= i_cfg.thresh);
            r_plain2 <= r_plain1;
            r_clear2 <= r_clear1;
            r_dest2  <= r_dest1;
            r_last2  <= r_last1;
            r_alpha2 <= r_alpha1;

            r_mix3   <= n_mix;
            r_ge3    <= r_ge2;
            r_plain3 <= r_plain2;
            r_clear3 <= r_clear2;
            r_dest3  <= r_dest2;
            r_last3  <= r_last2;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_q_ready) |=> (r_v3 && $stable(o_cls)))
        else $error("front output changed while stalled");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> o_ready)
        else $error("front not ready with empty output stage");
    a_push_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_v3)
        else $error("push without item");
`endif

endmodule
`default_nettype wire

/* sv/rtbp_fifo.sv */
`default_nettype none
module rtbp_fifo
    import rtbp_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_cls      o_data,
    input  wire logic i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count over depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

/* sv/rtbp_packer.sv */
`default_nettype none
module rtbp_packer
    import rtbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_pop,
    input  wire t_cls i_cls,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out_item o_item
);

    logic [7:0] r_acc, n_acc;
    logic [2:0] r_pos;
    logic       r_out_v;
    t_out_item  r_out;
    logic       emit;

    assign o_pop   = i_valid && (!r_out_v || i_ready);
    assign o_valid = r_out_v;
    assign o_item  = r_out;

    always_comb begin
        n_acc = r_acc | (8'(i_cls.pix_bit) << (3'd7 - r_pos));
        emit  = (r_pos == 3'd7) || i_cls.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_pop) begin
                if (emit) begin
                    r_acc   <= '0;
                    r_pos   <= '0;
                    r_out_v <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                    r_pos <= r_pos + 3'd1;
                    if (i_ready) begin
                        r_out_v <= 1'b0;
                    end
                end
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out.packed_byte  <= n_acc;
            r_out.valid_pixels <= 4'({1'b0, r_pos} + 4'd1);
            r_out.end_of_run   <= i_cls.last;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.valid_pixels != 4'd0 && o_item.valid_pixels <= 4'd8))
        else $error("pixel count out of range");
    a_short_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.end_of_run) |-> (o_item.valid_pixels == 4'd8))
        else $error("short byte without end of run");
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_item.packed_byte & (8'hFF >> o_item.valid_pixels)) == 8'd0))
        else $error("padding bits not clear");
`endif

endmodule
`default_nettype wire

/* sv/rgba_to_bilevel_packer_core.sv */
`default_nettype none
// Path: after the pixel closing a byte is accepted, the byte travels to o_out_valid
//   through three math stages, the queue and the output register.
// Throughput: one pixel per cycle unless stalled; the 8x9 weight multipliers and
//   blend multiplier are pipelined; at most one byte per cycle leaves the packer.
// Reset (i_rst_n low, synchronous): pipeline, queue and packer empty, weights
//   77/150/29, threshold 46.
module rgba_to_bilevel_packer_core
    import rtbp_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // pixel items in
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    // packed bytes out
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    // register writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data
);

    // Configuration registers; writes to unknown indexes are dropped.
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_w   <= RED_W_RST;
            r_cfg.green_w <= GREEN_W_RST;
            r_cfg.blue_w  <= BLUE_W_RST;
            r_cfg.thresh  <= THRESH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RED_W:   r_cfg.red_w   <= i_cfg_data;
                CFG_GREEN_W: r_cfg.green_w <= i_cfg_data;
                CFG_BLUE_W:  r_cfg.blue_w  <= i_cfg_data;
                CFG_THRESH:  r_cfg.thresh  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front: luma, alpha blend and threshold, one bit per pixel.
    logic q_ready, f_push;
    t_cls f_cls;

    rtbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_item),
        .o_push    (f_push),
        .i_q_ready (q_ready),
        .o_cls     (f_cls)
    );

    // Short queue decouples the math pipe from the serial packer.
    logic q_valid, q_pop;
    t_cls q_cls;

    rtbp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cls),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cls),
        .i_pop   (q_pop)
    );

    // Back: MSB-first packing into bytes, registered output.
    rtbp_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_cls   (q_cls),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
`default_nettype wire
